// ===== rtl/core/hfsx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsx_pkg
// shared types and constants of the header frame parser with sum and xor check
// ----------------------------------------------------------------------------
package hfsx_pkg;

  localparam int unsigned PAYLOAD_LEN = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned PAYLOAD_W   = 24;
  localparam int unsigned ERR_W       = 2;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;

  // payload bytes that fit into the packed field
  localparam int unsigned PACK_LEN = (PAYLOAD_LEN < PAYLOAD_W / BYTE_W) ?
                                     PAYLOAD_LEN : PAYLOAD_W / BYTE_W;
  localparam int unsigned CNT_W    = $clog2(PAYLOAD_LEN + 1);

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h55;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'hAA;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_FIRST  = 1'b0,
    CFG_HEADER_SECOND = 1'b1
  } cfg_idx_e;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE = 2'd0,
    ERR_SUM  = 2'd1,
    ERR_XOR  = 2'd2
  } err_e;

  typedef enum logic [2:0] {
    PH_HUNT1 = 3'd0,
    PH_HUNT2 = 3'd1,
    PH_DATA  = 3'd2,
    PH_SUM   = 3'd3,
    PH_XOR   = 3'd4
  } phase_e;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] rx_byte;
  } stage_t;

  typedef struct packed {
    logic                 ack;
    logic                 frame_ok;
    logic [ERR_W-1:0]     error_code;
    logic [PAYLOAD_W-1:0] payload;
  } res_t;

endpackage

// ===== rtl/core/hfsx_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsx byte and result channels
// valid/ready channels carrying received bytes and parser results
// ----------------------------------------------------------------------------
interface hfsx_byte_if;
  logic                      valid;
  logic                      ready;
  logic [hfsx_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface hfsx_result_if;
  logic                            valid;
  logic                            ready;
  logic                            ack;
  logic                            frame_ok;
  logic [hfsx_pkg::ERR_W-1:0]      error_code;
  logic [hfsx_pkg::PAYLOAD_W-1:0]  payload;

  modport source (output valid, output ack, output frame_ok, output error_code,
                  output payload, input ready);
  modport sink   (input valid, input ack, input frame_ok, input error_code,
                  input payload, output ready);
endinterface

// ===== rtl/core/hfsx_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsx_in_reg
// input register holding one received byte until the parser takes it
// ----------------------------------------------------------------------------
module hfsx_in_reg (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [hfsx_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                        advance_i,
  output logic                        ready_o,
  output hfsx_pkg::stage_t            stage_o
);
  import hfsx_pkg::*;

  logic              valid_q, valid_d;
  logic [BYTE_W-1:0] byte_q;

  assign ready_o = !valid_q || advance_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      byte_q <= rx_byte_i;
    end
  end

  assign stage_o.valid   = valid_q;
  assign stage_o.rx_byte = byte_q;

endmodule

// ===== rtl/core/hfsx_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsx_parser
// header hunt, payload capture, sum and xor checks, header registers
// ----------------------------------------------------------------------------
module hfsx_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hfsx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hfsx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  hfsx_pkg::stage_t                stage_i,
  input  logic                            advance_i,
  output hfsx_pkg::res_t                  res_o
);
  import hfsx_pkg::*;

  logic [BYTE_W-1:0] hdr_first_q, hdr_second_q;
  phase_e            phase_q, phase_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [BYTE_W-1:0] sum_q, sum_d;
  logic [BYTE_W-1:0] xor_q, xor_d;
  logic              store_we;
  logic [BYTE_W-1:0] store_q [PACK_LEN];
  logic [PAYLOAD_W-1:0] packed_pay;
  logic [BYTE_W-1:0] b;

  assign b = stage_i.rx_byte;

  // header registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HEADER_FIRST_RST;
      hdr_second_q <= HEADER_SECOND_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_HEADER_FIRST:  hdr_first_q  <= cfg_data_i[BYTE_W-1:0];
        CFG_HEADER_SECOND: hdr_second_q <= cfg_data_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    packed_pay = '0;
    for (int i = 0; i < PACK_LEN; i++) begin
      packed_pay[BYTE_W*i +: BYTE_W] = store_q[i];
    end
  end

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    sum_d    = sum_q;
    xor_d    = xor_q;
    store_we = 1'b0;
    res_o    = '0;
    case (phase_q)
      PH_HUNT1: begin
        if (b == hdr_first_q) begin
          res_o.ack = 1'b1;
          phase_d   = PH_HUNT2;
        end
      end
      PH_HUNT2: begin
        if (b == hdr_second_q) begin
          res_o.ack = 1'b1;
          phase_d   = PH_DATA;
          count_d   = '0;
          sum_d     = '0;
          xor_d     = '0;
        end else begin
          phase_d = PH_HUNT1;
        end
      end
      PH_DATA: begin
        sum_d     = sum_q + b;
        xor_d     = xor_q ^ b;
        store_we  = 1'b1;
        count_d   = count_q + 1'b1;
        res_o.ack = 1'b1;
        if (count_q == CNT_W'(PAYLOAD_LEN - 1)) begin
          phase_d = PH_SUM;
        end
      end
      PH_SUM: begin
        if (b == sum_q) begin
          res_o.ack = 1'b1;
          phase_d   = PH_XOR;
        end else begin
          res_o.error_code = ERR_SUM;
          phase_d          = PH_HUNT1;
        end
      end
      PH_XOR: begin
        if (b == xor_q) begin
          res_o.ack      = 1'b1;
          res_o.frame_ok = 1'b1;
          res_o.payload  = packed_pay;
        end else begin
          res_o.error_code = ERR_XOR;
        end
        phase_d = PH_HUNT1;
        count_d = '0;
        sum_d   = '0;
        xor_d   = '0;
      end
      default: begin
        phase_d = PH_HUNT1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      count_q <= '0;
      sum_q   <= '0;
      xor_q   <= '0;
    end else if (advance_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      xor_q   <= xor_d;
    end
  end

  // payload bytes beyond the packed field are not kept
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < PACK_LEN; i++) begin
      if (advance_i && store_we && count_q == CNT_W'(i)) begin
        store_q[i] <= b;
      end
    end
  end

endmodule

// ===== rtl/core/hfsx_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsx_out_reg
// result register; decides when the staged byte moves through the parser
// ----------------------------------------------------------------------------
module hfsx_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           stage_valid_i,
  input  hfsx_pkg::res_t res_i,
  input  logic           ready_i,
  output logic           advance_o,
  output logic           valid_o,
  output hfsx_pkg::res_t res_o
);
  import hfsx_pkg::*;

  logic valid_q, valid_d;
  res_t res_q;

  assign advance_o = stage_valid_i && (!valid_q || ready_i);
  assign valid_d   = advance_o || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/header_frame_sum_xor_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_frame_sum_xor_parser
// serial frame parser with two-byte header, 8-bit sum and 8-bit xor checks
// ----------------------------------------------------------------------------
// Takes one received byte per transaction and returns exactly one result per
// byte. The parser hunts for the first and then the second header byte (both
// programmable, reset 0x55 and 0xAA), stores PAYLOAD_LEN payload bytes while
// keeping a running sum and xor, then checks a sum byte and an xor byte. ack
// is set for every byte the parser accepts; a good xor byte sets frame_ok and
// shows the packed payload (first byte in bits 7..0), otherwise payload is 0.
// A failed check gives error_code 1 (sum) or 2 (xor) and restarts the hunt.
// Rate: one byte per clock cycle sustained while the result channel is ready;
// each byte passes through the input register and then the result register
// with the parser logic between them. While a finished result waits to be
// taken, the input register still takes one more byte and then holds off the
// input until the result moves on. The user must write the header registers
// only while no transaction is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module header_frame_sum_xor_parser (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [hfsx_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [hfsx_pkg::CFG_DATA_W-1:0] cfg_data_i,
  hfsx_byte_if.sink                       in_rx,
  hfsx_result_if.source                   out_tx
);
  import hfsx_pkg::*;

  stage_t stage;      // byte held in the input register
  res_t   res_comb;   // parser result for the held byte
  res_t   res_reg;    // registered result on the output channel
  logic   advance;    // held byte moves into the result register
  logic   out_valid;

  // input register: takes a new byte whenever the held one moves on
  hfsx_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_rx.valid),
    .rx_byte_i (in_rx.rx_byte),
    .advance_i (advance),
    .ready_o   (in_rx.ready),
    .stage_o   (stage)
  );

  // parser state, header registers and check logic
  hfsx_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .stage_i    (stage),
    .advance_i  (advance),
    .res_o      (res_comb)
  );

  // result register: state only advances when the result is captured
  hfsx_out_reg u_out_reg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stage_valid_i (stage.valid),
    .res_i         (res_comb),
    .ready_i       (out_tx.ready),
    .advance_o     (advance),
    .valid_o       (out_valid),
    .res_o         (res_reg)
  );

  assign out_tx.valid      = out_valid;
  assign out_tx.ack        = res_reg.ack;
  assign out_tx.frame_ok   = res_reg.frame_ok;
  assign out_tx.error_code = res_reg.error_code;
  assign out_tx.payload    = res_reg.payload;

endmodule

// ===== rtl/core/hfsx_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfsx_checker
// port-level checks of the frame parser, bound to the top level
// ----------------------------------------------------------------------------
module hfsx_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic                           ack_i,
  input logic                           frame_ok_i,
  input logic [hfsx_pkg::ERR_W-1:0]     error_code_i,
  input logic [hfsx_pkg::PAYLOAD_W-1:0] payload_i
);
  import hfsx_pkg::*;

  // a pending result stays until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transaction");

  // a good frame is acknowledged and carries no error
  a_ok_ack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_ok_i |-> ack_i && error_code_i == ERR_NONE)
    else $error("frame_ok without ack or with error");

  // payload only with a good frame, errors never acknowledged
  a_pay_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_ok_i |-> payload_i == '0 &&
      (error_code_i == ERR_NONE || !ack_i))
    else $error("payload without frame_ok or acked error");

  // a result appearing on an idle output comes from an input byte that passed the input register
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without input transaction");

endmodule

bind header_frame_sum_xor_parser hfsx_checker u_hfsx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_rx.valid),
  .in_ready_i   (in_rx.ready),
  .out_valid_i  (out_tx.valid),
  .out_ready_i  (out_tx.ready),
  .ack_i        (out_tx.ack),
  .frame_ok_i   (out_tx.frame_ok),
  .error_code_i (out_tx.error_code),
  .payload_i    (out_tx.payload)
);
